### design/utf8_decoder_with_space_flag_assert.svh
// Assertion macros used by the checker file.
`ifndef UTF8_DECODER_WITH_SPACE_FLAG_ASSERT_SVH
`define UTF8_DECODER_WITH_SPACE_FLAG_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define U8DEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk.
`define U8DEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/u8dec_pkg.sv
package u8dec_pkg;

   localparam int unsigned CpWidth = 21;

   typedef logic [CpWidth-1:0] cp_type;

   // Open sequence: continuation bytes still expected and payload so far.
   typedef struct packed {
      logic [1:0] pending;
      cp_type     partial;
   } dec_state_type;

   typedef struct packed {
      logic   valid;
      cp_type code_point;
      logic   is_space;
   } dec_result_type;

   // Byte tags.
   localparam logic [1:0] CONT_TAG  = 2'b10;
   localparam logic [2:0] LEAD2_TAG = 3'h6;
   localparam logic [3:0] LEAD3_TAG = 4'hE;
   localparam logic [4:0] LEAD4_TAG = 5'h1E;

   // Whitespace set.
   localparam cp_type SP_CTRL_LO  = 21'h000009;
   localparam cp_type SP_CTRL_HI  = 21'h00000D;
   localparam cp_type SP_SPACE    = 21'h000020;
   localparam cp_type SP_NEL      = 21'h000085;
   localparam cp_type SP_NBSP     = 21'h0000A0;
   localparam cp_type SP_OGHAM    = 21'h001680;
   localparam cp_type SP_EN_LO    = 21'h002000;
   localparam cp_type SP_EN_HI    = 21'h00200A;
   localparam cp_type SP_LINE_SEP = 21'h002028;
   localparam cp_type SP_PARA_SEP = 21'h002029;
   localparam cp_type SP_NNBSP    = 21'h00202F;
   localparam cp_type SP_MMSP     = 21'h00205F;
   localparam cp_type SP_IDEO     = 21'h003000;

   function automatic logic space_check(cp_type c);
      return (c >= SP_CTRL_LO && c <= SP_CTRL_HI) || c == SP_SPACE || c == SP_NEL ||
             c == SP_NBSP || c == SP_OGHAM || (c >= SP_EN_LO && c <= SP_EN_HI) ||
             c == SP_LINE_SEP || c == SP_PARA_SEP || c == SP_NNBSP ||
             c == SP_MMSP || c == SP_IDEO;
   endfunction

endpackage

### design/u8dec_step.sv
// One byte of decode: next sequence state and the optional code point.
module u8dec_step (
   input  logic [7:0]               byte_in,
   input  logic                     is_last,
   input  u8dec_pkg::dec_state_type state_cur,
   output u8dec_pkg::dec_state_type state_nxt,
   output u8dec_pkg::dec_result_type result
);

   logic                is_cont;
   logic [1:0]          pend_dec;
   u8dec_pkg::cp_type   acc;
   u8dec_pkg::cp_type   cp;
   logic                emit;

   assign is_cont  = (byte_in[7:6] == u8dec_pkg::CONT_TAG);
   assign pend_dec = state_cur.pending - 2'd1;
   assign acc      = {state_cur.partial[u8dec_pkg::CpWidth-7:0], byte_in[5:0]};

   always_comb begin
      state_nxt = '0;
      emit      = 1'b0;
      cp        = '0;
      if (state_cur.pending != 2'd0 && is_cont) begin
         if (pend_dec == 2'd0) begin
            emit = 1'b1;
            cp   = acc;
         end else if (!is_last) begin
            state_nxt.pending = pend_dec;
            state_nxt.partial = acc;
         end
      end else begin
         // Abandon any open sequence and take this byte as a lead.
         priority if (!byte_in[7]) begin
            emit = 1'b1;
            cp   = u8dec_pkg::cp_type'(byte_in);
         end else if (byte_in[7:5] == u8dec_pkg::LEAD2_TAG) begin
            state_nxt.pending = 2'd1;
            state_nxt.partial = u8dec_pkg::cp_type'(byte_in[4:0]);
         end else if (byte_in[7:4] == u8dec_pkg::LEAD3_TAG) begin
            state_nxt.pending = 2'd2;
            state_nxt.partial = u8dec_pkg::cp_type'(byte_in[3:0]);
         end else if (byte_in[7:3] == u8dec_pkg::LEAD4_TAG) begin
            state_nxt.pending = 2'd3;
            state_nxt.partial = u8dec_pkg::cp_type'(byte_in[2:0]);
         end else begin
            state_nxt = '0;
         end
         // Drop a lead that the string's end cuts short.
         if (is_last) begin
            state_nxt = '0;
         end
      end
   end

   assign result.valid      = emit;
   assign result.code_point = cp;
   assign result.is_space   = u8dec_pkg::space_check(cp);

endmodule

### design/utf8_decoder_with_space_flag.sv
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_byte_in[7:0], req_is_last
// rsp       out        rsp_valid/stall    rsp_code_point[20:0], rsp_is_space,
//                                         rsp_ends_string
//
// One byte per cycle sustained unless a stalled result holds it back; an accepted
// byte waits in the input register and is decoded into the result register as it
// advances. The sequence state loop (pending count, partial value) closes through
// the sequence state register. Reset is synchronous, active high; it clears valids
// and the open sequence. A stalled result only holds back bytes that would produce
// a result; bytes that merely open or extend a sequence keep flowing.
module utf8_decoder_with_space_flag (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_point,
   output logic        rsp_is_space,
   output logic        rsp_ends_string
);

   // Input register.
   logic        s1_valid_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;

   // Open sequence state.
   u8dec_pkg::dec_state_type  dec_state_ff;
   u8dec_pkg::dec_state_type  dec_state_in;
   u8dec_pkg::dec_result_type dec_result;

   // Result register.
   logic              rsp_valid_ff;
   u8dec_pkg::cp_type rsp_cp_ff;
   logic              rsp_space_ff;
   logic              rsp_last_ff;

   logic out_free;
   logic s1_advance;
   logic req_accept;

   u8dec_step u_step (
      .byte_in   (s1_byte_ff),
      .is_last   (s1_last_ff),
      .state_cur (dec_state_ff),
      .state_nxt (dec_state_in),
      .result    (dec_result)
   );

   // Result register can take a new item when empty or draining this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // Advance the held byte unless it has a result with nowhere to go.
   assign s1_advance = s1_valid_ff && (out_free || !dec_result.valid);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_byte_in;
         s1_last_ff <= req_is_last;
      end
   end

   // Commit the sequence state only when the held byte moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         dec_state_ff <= '0;
      end else if (s1_advance) begin
         dec_state_ff <= dec_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && dec_result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && dec_result.valid) begin
         rsp_cp_ff    <= dec_result.code_point;
         rsp_space_ff <= dec_result.is_space;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_point  = rsp_cp_ff;
   assign rsp_is_space    = rsp_space_ff;
   assign rsp_ends_string = rsp_last_ff;

endmodule

### design/u8dec_checker.sv
`include "utf8_decoder_with_space_flag_assert.svh"

module u8dec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_byte_in,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [20:0] rsp_code_point,
   input logic        rsp_is_space,
   input logic        rsp_ends_string
);

   // A stalled item stays offered.
   `U8DEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp item dropped under stall")

   // A stalled item keeps its payload.
   `U8DEC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_code_point) && $stable(rsp_is_space) && $stable(rsp_ends_string), "rsp payload changed under stall")

   // Nothing in the whitespace set lies above the ideographic space.
   `U8DEC_ASSERT_NOW(a_space_range, clock, reset, rsp_valid && rsp_code_point > 21'h003000, !rsp_is_space, "space flag on code point above whitespace range")

   // Input backs up only when a result is waiting downstream.
   `U8DEC_ASSERT_NOW(a_stall_cause, clock, reset, !rsp_valid, !req_stall, "req stalled with empty result register")

   // Reset empties the result register.
   `U8DEC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")

endmodule

bind utf8_decoder_with_space_flag u8dec_checker u_u8dec_checker (.*);

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

   // One decoded character as it leaves the block.
   typedef struct packed {
      u8dec_pkg::cp_type cp;
      logic              space;
      logic              ends;
   } decoded_char_type;

   // One row of the directed table. When fixed is set, has/cp/space/ends hold the
   // typed-in expectation; otherwise the row is checked against the predictor.
   typedef struct packed {
      logic [7:0]        b;
      logic              last;
      logic              fixed;
      logic              has;
      u8dec_pkg::cp_type cp;
      logic              space;
      logic              ends;
   } stim_row_type;

   localparam int NumDirected = 25;
   localparam int RandomBytes = 1000;
   localparam int SettleCycles = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'h00;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [20:0] rsp_code_point;
   logic        rsp_is_space;
   logic        rsp_ends_string;

   utf8_decoder_with_space_flag u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_in     (req_byte_in),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_is_space    (rsp_is_space),
      .rsp_ends_string (rsp_ends_string)
   );

   always #10 clock = ~clock;

   // Predictor state: continuation bytes still owed and payload gathered so far.
   logic [1:0]        seq_left = 2'd0;
   u8dec_pkg::cp_type seq_acc = '0;

   // Characters decoded by the predictor and not yet seen at the output.
   decoded_char_type pending_chars [$];

   int errors = 0;
   int n_bytes = 0;
   int n_chars = 0;
   int n_spaces = 0;
   int n_ends = 0;
   int burst_left = 0;

   // Directed items: extremes, every lead length, and every way a sequence dies.
   stim_row_type directed_rows [NumDirected] = '{
      // single-byte extremes and stray bytes, expectations typed in
      '{8'h00, 1'b0, 1'b1, 1'b1, 21'h000000, 1'b0, 1'b0},
      '{8'h7F, 1'b1, 1'b1, 1'b1, 21'h00007F, 1'b0, 1'b1},
      '{8'h20, 1'b0, 1'b1, 1'b1, 21'h000020, 1'b1, 1'b0},
      '{8'h80, 1'b0, 1'b1, 1'b0, 21'h000000, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b1, 1'b0, 21'h000000, 1'b0, 1'b0},
      // two-byte next line (whitespace)
      '{8'hC2, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'h85, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      // three-byte ogham space mark
      '{8'hE1, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'h9A, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      // four-byte all-ones payload, completing on the string's last byte
      '{8'hF7, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'hBF, 1'b1, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      // open sequence broken by an ASCII byte, which then decodes alone
      '{8'hE3, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'h41, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      // cut short by string end mid-sequence, then a stray continuation
      '{8'hE2, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      // lead byte that is itself the last byte
      '{8'hC0, 1'b1, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      // overlong form of zero is accepted
      '{8'hC0, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      // ideographic space ending a string
      '{8'hE3, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 21'h0, 1'b0, 1'b0}
   };

   function automatic logic is_unicode_space(u8dec_pkg::cp_type c);
      return c inside {[u8dec_pkg::SP_CTRL_LO:u8dec_pkg::SP_CTRL_HI],
                       u8dec_pkg::SP_SPACE, u8dec_pkg::SP_NEL, u8dec_pkg::SP_NBSP,
                       u8dec_pkg::SP_OGHAM,
                       [u8dec_pkg::SP_EN_LO:u8dec_pkg::SP_EN_HI],
                       u8dec_pkg::SP_LINE_SEP, u8dec_pkg::SP_PARA_SEP,
                       u8dec_pkg::SP_NNBSP, u8dec_pkg::SP_MMSP, u8dec_pkg::SP_IDEO};
   endfunction

   // Advance the predictor by one byte; got says whether a character completes.
   task automatic decode_byte(input logic [7:0] b, input logic last,
                              output logic got, output decoded_char_type ch);
      got = 1'b0;
      ch  = '0;
      if (seq_left != 2'd0 && b[7:6] == u8dec_pkg::CONT_TAG) begin
         // shift in six payload bits; the top bits fall off past 21
         seq_acc  = {seq_acc[u8dec_pkg::CpWidth-7:0], b[5:0]};
         seq_left = seq_left - 2'd1;
         got      = (seq_left == 2'd0);
      end else begin
         // drop any open sequence and treat the byte as a fresh lead
         seq_left = 2'd0;
         seq_acc  = '0;
         if (!b[7]) begin
            seq_acc = u8dec_pkg::cp_type'(b);
            got     = 1'b1;
         end else if (b[7:5] == u8dec_pkg::LEAD2_TAG) begin
            seq_left = 2'd1;
            seq_acc  = u8dec_pkg::cp_type'(b[4:0]);
         end else if (b[7:4] == u8dec_pkg::LEAD3_TAG) begin
            seq_left = 2'd2;
            seq_acc  = u8dec_pkg::cp_type'(b[3:0]);
         end else if (b[7:3] == u8dec_pkg::LEAD4_TAG) begin
            seq_left = 2'd3;
            seq_acc  = u8dec_pkg::cp_type'(b[2:0]);
         end
      end
      if (got) begin
         ch.cp    = seq_acc;
         ch.space = is_unicode_space(seq_acc);
         ch.ends  = last;
      end
      // a completed character or a string end leaves no sequence open
      if (got || last) begin
         seq_left = 2'd0;
         seq_acc  = '0;
      end
   endtask

   // Offer one item; hold it until accepted, then record what it should produce.
   // Valid is only lowered at a gap, so it never toggles twice in one step.
   task automatic push_byte(input stim_row_type row);
      logic             got;
      decoded_char_type ch;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
      req_valid   <= 1'b1;
      req_byte_in <= row.b;
      req_is_last <= row.last;
      do @(posedge clock); while (req_stall !== 1'b0);
      burst_left--;
      n_bytes++;
      decode_byte(row.b, row.last, got, ch);
      if (row.fixed) begin
         got      = row.has;
         ch.cp    = row.cp;
         ch.space = row.space;
         ch.ends  = row.ends;
      end
      if (got)
         pending_chars = {pending_chars, ch};
   endtask

   // Encode a code point in len bytes and send the first keep of them; the
   // string-end flag, if asked for, rides on the last byte sent.
   task automatic send_char(input u8dec_pkg::cp_type cp, input int len, input int keep,
                            input logic ends);
      logic [7:0]   seq [0:3];
      stim_row_type row;
      case (len)
         1: begin
            seq[0] = {1'b0, cp[6:0]};
         end
         2: begin
            seq[0] = {u8dec_pkg::LEAD2_TAG, cp[10:6]};
            seq[1] = {u8dec_pkg::CONT_TAG, cp[5:0]};
         end
         3: begin
            seq[0] = {u8dec_pkg::LEAD3_TAG, cp[15:12]};
            seq[1] = {u8dec_pkg::CONT_TAG, cp[11:6]};
            seq[2] = {u8dec_pkg::CONT_TAG, cp[5:0]};
         end
         default: begin
            seq[0] = {u8dec_pkg::LEAD4_TAG, cp[20:18]};
            seq[1] = {u8dec_pkg::CONT_TAG, cp[17:12]};
            seq[2] = {u8dec_pkg::CONT_TAG, cp[11:6]};
            seq[3] = {u8dec_pkg::CONT_TAG, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) begin
         row      = '0;
         row.b    = seq[i];
         row.last = ends && (i == keep - 1);
         push_byte(row);
      end
   endtask

   // Hold off the sender until every expected character has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_chars.size() != 0);
   endtask

   // Receiver stall pattern: long phases of free flow, random stalls, or runs
   // of stall/free of random length.
   int stall_mode = 0;
   int stall_mode_left = 0;
   int stall_hold = 0;

   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      <= $urandom_range(0, 2);
         stall_mode_left <= $urandom_range(32, 200);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         default: begin
            if (stall_hold == 0) begin
               rsp_stall  <= ~rsp_stall;
               stall_hold <= $urandom_range(1, 12);
            end else begin
               stall_hold <= stall_hold - 1;
            end
         end
      endcase
   end

   // Compare every accepted result with the oldest expected character.
   decoded_char_type seen_char;
   decoded_char_type want_char;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         seen_char = '{rsp_code_point, rsp_is_space, rsp_ends_string};
         if (pending_chars.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected result cp=%h space=%b ends=%b", $realtime,
                        seen_char.cp, seen_char.space, seen_char.ends);
         end else begin
            want_char = pending_chars.pop_front();
            n_chars++;
            n_spaces += want_char.space;
            n_ends   += want_char.ends;
            if (seen_char !== want_char) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: expected cp=%h space=%b ends=%b, got cp=%h space=%b ends=%b",
                           $realtime, want_char.cp, want_char.space, want_char.ends,
                           seen_char.cp, seen_char.space, seen_char.ends);
            end
         end
      end
   end

   // Main sequence: reset, directed table, random text, final drain and verdict.
   initial begin
      int                pick;
      int                len;
      logic              ends;
      logic              drained;
      u8dec_pkg::cp_type cp;
      stim_row_type      row;
      drained = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_byte(directed_rows[i]);
      wait_drained();

      // Mostly well-formed characters with random payloads, some whitespace
      // picks, some truncated sequences and a little raw noise.
      while (n_bytes < NumDirected + RandomBytes) begin
         if (!drained && n_bytes >= NumDirected + RandomBytes / 2) begin
            wait_drained();
            drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         ends = ($urandom_range(0, 5) == 0);
         if (pick < 15) begin
            send_char(u8dec_pkg::cp_type'($urandom_range(0, 127)), 1, 1, ends);
         end else if (pick < 27) begin
            case ($urandom_range(0, 12))
               0:  cp = u8dec_pkg::SP_CTRL_LO + u8dec_pkg::cp_type'($urandom_range(0, 4));
               1:  cp = u8dec_pkg::SP_SPACE;
               2:  cp = u8dec_pkg::SP_NEL;
               3:  cp = u8dec_pkg::SP_NBSP;
               4:  cp = u8dec_pkg::SP_OGHAM;
               5:  cp = u8dec_pkg::SP_EN_LO + u8dec_pkg::cp_type'($urandom_range(0, 10));
               6:  cp = u8dec_pkg::SP_LINE_SEP;
               7:  cp = u8dec_pkg::SP_PARA_SEP;
               8:  cp = u8dec_pkg::SP_NNBSP;
               9:  cp = u8dec_pkg::SP_MMSP;
               10: cp = u8dec_pkg::SP_IDEO;
               11: cp = u8dec_pkg::SP_EN_HI + u8dec_pkg::cp_type'(1);
               default: cp = u8dec_pkg::SP_CTRL_LO - u8dec_pkg::cp_type'(1);
            endcase
            len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            send_char(cp, len, len, ends);
         end else if (pick < 85) begin
            len = $urandom_range(2, 4);
            send_char(u8dec_pkg::cp_type'($urandom), len, len, ends);
         end else if (pick < 93) begin
            // truncated: either the string ends or the next lead breaks it
            len = $urandom_range(2, 4);
            send_char(u8dec_pkg::cp_type'($urandom), len, $urandom_range(1, len - 1), ends);
         end else begin
            row      = '0;
            row.b    = 8'($urandom);
            row.last = ($urandom_range(0, 3) == 0);
            push_byte(row);
         end
      end

      req_valid <= 1'b0;
      while (pending_chars.size() != 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("Fed %0d bytes of text; checked %0d decoded characters,", n_bytes, n_chars);
      $display("%0d of them whitespace and %0d closing a string.", n_spaces, n_ends);
      if (errors == 0) begin
         $display("utf8_decoder_with_space_flag: match");
      end else begin
         $display("%0d bad results", errors);
         $display("utf8_decoder_with_space_flag: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("timeout with %0d characters outstanding", pending_chars.size());
      $display("utf8_decoder_with_space_flag: mismatch");
      $finish;
   end

endmodule
